/* sv/bbg_pkg.sv */
package bbg_pkg;

  localparam int MAX_RADIUS  = 7;
  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 1024;
  localparam int STORE_ROWS  = 2 * MAX_RADIUS + 1;
  localparam int STORE_DEPTH = STORE_ROWS * MAX_WIDTH;

  localparam int PIX_W   = 8;
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int WID_W   = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W   = $clog2(MAX_HEIGHT + 1);
  localparam int SLOT_W  = $clog2(STORE_ROWS);
  localparam int SIDE_W  = $clog2(STORE_ROWS + 1);
  localparam int RAD_W   = $clog2(MAX_RADIUS + 1);
  localparam int ADDR_W  = $clog2(STORE_DEPTH);
  localparam int POS_W   = ROW_W + WID_W;

  // Register file layout, fixed by the field widths.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_RAD_W  = 3;
  localparam int CFG_DIM_W  = 11;

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

  localparam logic OP_DATA  = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // Reciprocal of the window area, scaled by 2^16 and rounded up.
  localparam int RECIP_W     = 13;
  localparam int RECIP_SHIFT = 16;
  localparam int PROD_W      = PIX_W + RECIP_W;

  typedef struct packed {
    logic             operation;
    logic [PIX_W-1:0] pixel_in;
  } in_word_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             last_of_frame;
  } out_word_t;

  typedef struct packed {
    logic [RAD_W-1:0]  radius;
    logic [SIDE_W-1:0] side;
    logic [WID_W-1:0]  width;
    logic [ROW_W-1:0]  height;
  } geom_t;

  typedef struct packed {
    logic clear;
    logic take;
    logic pass;
  } acc_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_PASS,
    ST_WAIT,
    ST_FIN
  } seq_state_t;

  function automatic logic [RECIP_W-1:0] area_recip(input logic [3:0] r);
    logic [RECIP_W-1:0] m;
    case (r)
      4'd1:    m = 13'd7282;
      4'd2:    m = 13'd2622;
      4'd3:    m = 13'd1338;
      4'd4:    m = 13'd810;
      4'd5:    m = 13'd542;
      4'd6:    m = 13'd388;
      4'd7:    m = 13'd292;
      4'd8:    m = 13'd227;
      4'd9:    m = 13'd182;
      4'd10:   m = 13'd149;
      4'd11:   m = 13'd124;
      4'd12:   m = 13'd105;
      4'd13:   m = 13'd90;
      4'd14:   m = 13'd78;
      4'd15:   m = 13'd69;
      default: m = 13'd0;
    endcase
    return m;
  endfunction

  function automatic logic [ADDR_W-1:0] store_addr(input logic [SLOT_W-1:0] slot,
                                                   input logic [COL_W-1:0] col);
    return ADDR_W'(slot) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col);
  endfunction

endpackage

/* sv/bbg_ram.sv */
module bbg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* sv/bbg_acc.sv */
module bbg_acc
  import bbg_pkg::*;
(
  input  logic             clk,
  input  acc_ctl_t         ctl,
  input  logic [RAD_W-1:0] radius,
  input  logic [PIX_W-1:0] rd_data,
  output logic [PIX_W-1:0] sum
);

  logic [PIX_W-1:0]  sum_r;
  logic [PIX_W-1:0]  sum_nxt;
  logic [PROD_W-1:0] prod;
  logic [PIX_W-1:0]  quot;

  // Exact quotient of an 8-bit pixel by the window area via a scaled reciprocal.
  assign prod = PROD_W'(rd_data) * PROD_W'(area_recip(4'(radius)));
  assign quot = prod[RECIP_SHIFT +: PIX_W];

  always_comb begin
    sum_nxt = sum_r;
    if (ctl.clear) begin
      sum_nxt = '0;
    end else if (ctl.take) begin
      if (ctl.pass) begin
        sum_nxt = rd_data;
      end else begin
        sum_nxt = sum_r + quot;
      end
    end
  end

  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
  end

  assign sum = sum_r;

endmodule

/* sv/bbg_ctrl.sv */
module bbg_ctrl
  import bbg_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  geom_t             geom,
  input  logic              cfg_clear,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_word_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_word_t         out_data,
  output logic              ram_wr_en,
  output logic [ADDR_W-1:0] ram_wr_addr,
  output logic [PIX_W-1:0]  ram_wr_data,
  output logic              ram_rd_en,
  output logic [ADDR_W-1:0] ram_rd_addr,
  output acc_ctl_t          acc_ctl,
  input  logic [PIX_W-1:0]  acc_sum
);

  seq_state_t        state_r, state_nxt;
  logic [ROW_W-1:0]  in_row_r, in_row_nxt;
  logic [COL_W-1:0]  in_col_r, in_col_nxt;
  logic [SLOT_W-1:0] in_slot_r, in_slot_nxt;
  logic [ROW_W-1:0]  out_row_r, out_row_nxt;
  logic [COL_W-1:0]  out_col_r, out_col_nxt;
  logic [SLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic [SLOT_W-1:0] win_slot_r, win_slot_nxt;
  logic [SLOT_W-1:0] dy_r, dy_nxt;
  logic [SLOT_W-1:0] dx_r, dx_nxt;
  logic              rd_pend_r, rd_pend_nxt;
  logic              pass_r, pass_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_word_t         out_word_r, out_word_nxt;

  logic              input_done;
  logic              past_lag;
  logic [POS_W-1:0]  in_pos;
  logic [POS_W-1:0]  lag;
  logic              interior;
  logic              in_col_end;
  logic              out_col_end;
  logic              out_last;
  logic              is_data;
  logic              emit_go;
  logic [SIDE_W-1:0] side_m1;
  logic [SIDE_W-1:0] win_start;
  logic [COL_W-1:0]  win_col;

  assign side_m1     = geom.side - SIDE_W'(1);
  assign input_done  = in_row_r >= geom.height;
  // Raster position of the incoming pixel against the output lag of radius rows
  // plus radius pixels; rows narrower than the radius make the lag span extra rows.
  assign in_pos      = POS_W'(in_row_r) * POS_W'(geom.width) + POS_W'(in_col_r);
  assign lag         = POS_W'(geom.radius) * POS_W'(geom.width) + POS_W'(geom.radius);
  assign past_lag    = in_pos >= lag;
  assign interior    = (out_row_r >= ROW_W'(geom.radius)) &&
                       ((ROW_W + 1)'(out_row_r) + (ROW_W + 1)'(geom.radius) <
                        (ROW_W + 1)'(geom.height)) &&
                       (out_col_r >= COL_W'(geom.radius)) &&
                       ((WID_W + 1)'(out_col_r) + (WID_W + 1)'(geom.radius) <
                        (WID_W + 1)'(geom.width));
  assign in_col_end  = WID_W'(in_col_r) + WID_W'(1) >= geom.width;
  assign out_col_end = WID_W'(out_col_r) + WID_W'(1) >= geom.width;
  assign out_last    = (out_row_r + ROW_W'(1) == geom.height) &&
                       (WID_W'(out_col_r) + WID_W'(1) == geom.width);
  assign is_data     = (in_data.operation == OP_DATA) && !input_done;
  assign emit_go     = is_data ? past_lag : (input_done && (out_row_r < geom.height));

  // First window row is radius rows above the output row, modulo the store height.
  assign win_start   = (SIDE_W'(out_slot_r) >= SIDE_W'(geom.radius)) ?
                       SIDE_W'(out_slot_r) - SIDE_W'(geom.radius) :
                       SIDE_W'(out_slot_r) + geom.side - SIDE_W'(geom.radius);
  assign win_col     = out_col_r - COL_W'(geom.radius) + COL_W'(dx_r);

  always_comb begin
    state_nxt     = state_r;
    in_row_nxt    = in_row_r;
    in_col_nxt    = in_col_r;
    in_slot_nxt   = in_slot_r;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    out_slot_nxt  = out_slot_r;
    win_slot_nxt  = win_slot_r;
    dy_nxt        = dy_r;
    dx_nxt        = dx_r;
    rd_pend_nxt   = 1'b0;
    pass_nxt      = pass_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    in_stall      = 1'b1;
    ram_wr_en     = 1'b0;
    ram_wr_addr   = store_addr(in_slot_r, in_col_r);
    ram_wr_data   = in_data.pixel_in;
    ram_rd_en     = 1'b0;
    ram_rd_addr   = store_addr(win_slot_r, win_col);
    acc_ctl       = '{clear: 1'b0, take: rd_pend_r, pass: pass_r};

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (is_data) begin
            ram_wr_en = 1'b1;
            if (in_col_end) begin
              in_col_nxt = '0;
              in_row_nxt = in_row_r + ROW_W'(1);
              in_slot_nxt = (SIDE_W'(in_slot_r) == side_m1) ? '0 : in_slot_r + SLOT_W'(1);
            end else begin
              in_col_nxt = in_col_r + COL_W'(1);
            end
          end
          if (emit_go) begin
            acc_ctl.clear = 1'b1;
            win_slot_nxt  = SLOT_W'(win_start);
            dy_nxt        = '0;
            dx_nxt        = '0;
            pass_nxt      = !interior;
            state_nxt     = interior ? ST_SUM : ST_PASS;
          end
        end
      end
      ST_SUM: begin
        ram_rd_en   = 1'b1;
        rd_pend_nxt = 1'b1;
        if (SIDE_W'(dx_r) == side_m1) begin
          dx_nxt       = '0;
          dy_nxt       = dy_r + SLOT_W'(1);
          win_slot_nxt = (SIDE_W'(win_slot_r) == side_m1) ? '0 : win_slot_r + SLOT_W'(1);
          if (SIDE_W'(dy_r) == side_m1) begin
            state_nxt = ST_WAIT;
          end
        end else begin
          dx_nxt = dx_r + SLOT_W'(1);
        end
      end
      ST_PASS: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = store_addr(out_slot_r, out_col_r);
        rd_pend_nxt = 1'b1;
        state_nxt   = ST_WAIT;
      end
      ST_WAIT: begin
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = '{pixel_out: acc_sum, last_of_frame: out_last};
          state_nxt     = ST_IDLE;
          if (out_last) begin
            in_row_nxt   = '0;
            in_col_nxt   = '0;
            in_slot_nxt  = '0;
            out_row_nxt  = '0;
            out_col_nxt  = '0;
            out_slot_nxt = '0;
          end else if (out_col_end) begin
            out_col_nxt  = '0;
            out_row_nxt  = out_row_r + ROW_W'(1);
            out_slot_nxt = (SIDE_W'(out_slot_r) == side_m1) ? '0 : out_slot_r + SLOT_W'(1);
          end else begin
            out_col_nxt = out_col_r + COL_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // A register write abandons the frame in progress.
    if (cfg_clear) begin
      in_row_nxt   = '0;
      in_col_nxt   = '0;
      in_slot_nxt  = '0;
      out_row_nxt  = '0;
      out_col_nxt  = '0;
      out_slot_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      in_row_r    <= '0;
      in_col_r    <= '0;
      in_slot_r   <= '0;
      out_row_r   <= '0;
      out_col_r   <= '0;
      out_slot_r  <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_row_r    <= in_row_nxt;
      in_col_r    <= in_col_nxt;
      in_slot_r   <= in_slot_nxt;
      out_row_r   <= out_row_nxt;
      out_col_r   <= out_col_nxt;
      out_slot_r  <= out_slot_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_slot_r <= win_slot_nxt;
    dy_r       <= dy_nxt;
    dx_r       <= dx_nxt;
    pass_r     <= pass_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

endmodule

/* sv/box_blur_gray_window_core.sv */
// Streaming N x N box blur on 8-bit grayscale pixels in raster order, N = 2*radius+1.
// Each window pixel is divided by N*N with truncation before the quotients are summed;
// pixels within radius of an edge pass through unchanged. Results trail the input by
// radius rows plus radius pixels, and drain words flush the pending results at frame
// end. The line store is a single RAM with one write and one read port, and the window
// is summed one read per cycle: a blurred pixel holds off input through its N*N window
// reads, a wait and a finish state, a passed-through pixel through one read, the wait and
// the finish state, and a word with no result is not held. A result waiting in the output
// register does not hold off the next input word. Register writes restart the frame.
module box_blur_gray_window_core
  import bbg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_data
);

  logic [CFG_RAD_W-1:0] radius_r;
  logic [CFG_DIM_W-1:0] width_r;
  logic [CFG_DIM_W-1:0] height_r;
  logic                 cfg_hit;
  geom_t                geom;
  logic [RAD_W-1:0]     eff_radius;

  logic                 ram_wr_en;
  logic [ADDR_W-1:0]    ram_wr_addr;
  logic [PIX_W-1:0]     ram_wr_data;
  logic                 ram_rd_en;
  logic [ADDR_W-1:0]    ram_rd_addr;
  logic [PIX_W-1:0]     ram_rd_data;
  acc_ctl_t             acc_ctl;
  logic [PIX_W-1:0]     acc_sum;

  assign cfg_hit = cfg_wr_en &&
                   (cfg_index == REG_RADIUS || cfg_index == REG_WIDTH ||
                    cfg_index == REG_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= CFG_RAD_W'(1);
      width_r  <= CFG_DIM_W'(MAX_WIDTH);
      height_r <= CFG_DIM_W'(MAX_HEIGHT);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_RADIUS: radius_r <= cfg_wdata[CFG_RAD_W-1:0];
        REG_WIDTH:  width_r  <= cfg_wdata[CFG_DIM_W-1:0];
        REG_HEIGHT: height_r <= cfg_wdata[CFG_DIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Out-of-range settings are clamped to the supported range.
  always_comb begin
    if (radius_r == '0) begin
      eff_radius = RAD_W'(1);
    end else if (32'(radius_r) > MAX_RADIUS) begin
      eff_radius = RAD_W'(MAX_RADIUS);
    end else begin
      eff_radius = RAD_W'(radius_r);
    end
    geom.radius = eff_radius;
    geom.side   = SIDE_W'(eff_radius) + SIDE_W'(eff_radius) + SIDE_W'(1);
    if (width_r == '0) begin
      geom.width = WID_W'(1);
    end else if (32'(width_r) > MAX_WIDTH) begin
      geom.width = WID_W'(MAX_WIDTH);
    end else begin
      geom.width = WID_W'(width_r);
    end
    if (height_r == '0) begin
      geom.height = ROW_W'(1);
    end else if (32'(height_r) > MAX_HEIGHT) begin
      geom.height = ROW_W'(MAX_HEIGHT);
    end else begin
      geom.height = ROW_W'(height_r);
    end
  end

  bbg_ram #(
    .WIDTH(PIX_W),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_en  (ram_rd_en),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

  bbg_acc u_acc (
    .clk    (clk),
    .ctl    (acc_ctl),
    .radius (eff_radius),
    .rd_data(ram_rd_data),
    .sum    (acc_sum)
  );

  bbg_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .geom       (geom),
    .cfg_clear  (cfg_hit),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .ram_wr_en  (ram_wr_en),
    .ram_wr_addr(ram_wr_addr),
    .ram_wr_data(ram_wr_data),
    .ram_rd_en  (ram_rd_en),
    .ram_rd_addr(ram_rd_addr),
    .acc_ctl    (acc_ctl),
    .acc_sum    (acc_sum)
  );

endmodule

/* tb/box_blur_gray_window_core_tb.sv */
`timescale 1ns / 100ps

module box_blur_gray_window_core_tb;
  import bbg_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 300;
  localparam int RANDOM_WORDS = 100;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_RADIUS;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_word_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_word_t             out_data;

  box_blur_gray_window_core DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #6 clk = ~clk;

  // Predictor state: line store, raster counters and register copies.
  logic [7:0]  blur_store [STORE_DEPTH];
  int unsigned in_row, in_col, out_row, out_col;
  int unsigned radius_reg, width_reg, height_reg;
  bit          frame_closed;

  out_word_t   expected_pixels[$];
  int          mismatches = 0;
  int          sent_words = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  bit          hold_request = 1'b0;
  int          hold_left = 0;
  int          quiet_cycles = 0;

  function automatic int unsigned clamp(int unsigned v, int unsigned hi);
    if (v < 1) v = 1;
    if (v > hi) v = hi;
    return v;
  endfunction

  function automatic logic [7:0] store_pixel(int unsigned row, int unsigned col,
                                             int unsigned side);
    return blur_store[(row % side) * MAX_WIDTH + col];
  endfunction

  function automatic out_word_t blurred_pixel(int unsigned r, int unsigned w,
                                              int unsigned h);
    int unsigned side, area, sum;
    out_word_t   res;
    side = 2 * r + 1;
    area = side * side;
    sum = 0;
    if (out_row >= r && out_row + r < h && out_col >= r && out_col + r < w) begin
      for (int unsigned dy = 0; dy < side; dy++)
        for (int unsigned dx = 0; dx < side; dx++)
          sum += store_pixel(out_row - r + dy, out_col - r + dx, side) / area;
    end else begin
      sum = store_pixel(out_row, out_col, side);
    end
    res.pixel_out = sum[7:0];
    res.last_of_frame = (out_row + 1 == h) && (out_col + 1 == w);
    if (res.last_of_frame) begin
      in_row = 0; in_col = 0; out_row = 0; out_col = 0;
      frame_closed = 1'b1;
    end else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
    return res;
  endfunction

  function automatic void blur_step(in_word_t wd);
    int unsigned r, w, h, side, pos;
    bit          input_done;
    r = radius_reg;
    if (r < 1) r = 1;
    if (r > MAX_RADIUS) r = MAX_RADIUS;
    w = clamp(width_reg, MAX_WIDTH);
    h = clamp(height_reg, MAX_HEIGHT);
    side = 2 * r + 1;
    input_done = in_row >= h;
    if (wd.operation == OP_DATA && !input_done) begin
      pos = in_row * w + in_col;
      blur_store[(in_row % side) * MAX_WIDTH + in_col] = wd.pixel_in;
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
      end
      if (pos >= r * w + r) expected_pixels.push_back(blurred_pixel(r, w, h));
    end else if (input_done && out_row < h) begin
      expected_pixels.push_back(blurred_pixel(r, w, h));
    end
  endfunction

  // Receiver: random stalls plus an optional long hold-off.
  always @(posedge clk) begin
    if (hold_request) begin
      hold_left <= 3000;
      hold_request = 1'b0;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Each accepted result word is checked against the oldest expectation.
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: pixel %0d last %0b",
                   out_data.pixel_out, out_data.last_of_frame);
      end else begin
        want = expected_pixels.pop_front();
        if (want.pixel_out !== out_data.pixel_out ||
            want.last_of_frame !== out_data.last_of_frame) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected pixel %0d last %0b, got pixel %0d last %0b",
                     want.pixel_out, want.last_of_frame,
                     out_data.pixel_out, out_data.last_of_frame);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("box_blur_gray_window_core verification failed");
      $finish;
    end
  end

  task automatic send_word(logic op, logic [7:0] px);
    in_word_t wd;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    wd.operation = op;
    wd.pixel_in = px;
    in_valid <= 1'b1;
    in_data <= wd;
    do @(posedge clk); while (in_stall);
    blur_step(wd);
    sent_words++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_RADIUS) radius_reg = value & 7;
    else if (idx == REG_WIDTH) width_reg = value & 11'h7FF;
    else height_reg = value & 11'h7FF;
    in_row = 0; in_col = 0; out_row = 0; out_col = 0;
  endtask

  task automatic set_geometry(int unsigned r, int unsigned w, int unsigned h);
    wait_idle();
    write_reg(REG_RADIUS, r);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
  endtask

  // fill: 0 random, 1 all zero, 2 all full scale. Stops early after cut words
  // when cut is not negative, leaving the frame to be aborted.
  task automatic blur_frame(int fill, int cut, bit noisy);
    int unsigned total;
    logic [7:0]  px;
    total = clamp(width_reg, MAX_WIDTH) * clamp(height_reg, MAX_HEIGHT);
    frame_closed = 1'b0;
    for (int unsigned i = 0; i < total; i++) begin
      if (cut >= 0 && i >= cut) return;
      // A drain word mid-frame must produce nothing.
      if (noisy && $urandom_range(99) < 5) send_word(OP_DRAIN, 8'($urandom));
      px = (fill == 1) ? 8'h00 : (fill == 2) ? 8'hFF : 8'($urandom);
      send_word(OP_DATA, px);
    end
    while (!frame_closed) begin
      // A data word past the frame end is dropped and flushes like a drain.
      if (noisy && $urandom_range(99) < 30) send_word(OP_DATA, 8'($urandom));
      else send_word(OP_DRAIN, 8'($urandom));
    end
    if (noisy && $urandom_range(99) < 30) send_word(OP_DRAIN, 8'($urandom));
  endtask

  task automatic test_directed();
    set_geometry(1, 4, 4);
    blur_frame(2, -1, 1'b0);
    send_word(OP_DRAIN, 8'hFF);
    set_geometry(7, 15, 15);
    blur_frame(0, -1, 1'b0);
    set_geometry(0, 0, 0);
    blur_frame(0, -1, 1'b1);
    set_geometry(2, 3, 3);
    blur_frame(0, -1, 1'b1);
  endtask

  // Rows narrower than the radius, and widths at and beyond the line store, the latter
  // clamped; the wide frames are cut short and aborted.
  task automatic test_extreme_sizes();
    set_geometry(7, 1, 20);
    blur_frame(0, -1, 1'b0);
    set_geometry(1, 1024, 2);
    blur_frame(0, 20, 1'b0);
    set_geometry(3, 2047, 1);
    blur_frame(0, 20, 1'b0);
  endtask

  task automatic test_aborted_frame();
    set_geometry(2, 9, 8);
    blur_frame(0, 24, 1'b1);
    set_geometry(1, 4, 4);
    blur_frame(1, -1, 1'b1);
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_geometry(1, 6, 6);
    hold_request = 1'b1;
    blur_frame(0, -1, 1'b0);
  endtask

  task automatic test_random_frames();
    int start, r, w, h;
    start = sent_words;
    while (sent_words - start < RANDOM_WORDS) begin
      case ((sent_words - start) * 3 / RANDOM_WORDS)
        0: begin send_idle_pct = 8; recv_idle_pct = 84; end
        1: begin send_idle_pct = 84; recv_idle_pct = 8; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      r = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 7);
      w = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 20);
      h = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 12);
      set_geometry(r, w, h);
      if ($urandom_range(9) == 0) blur_frame(0, $urandom_range(0, 30), 1'b1);
      else blur_frame(0, -1, 1'b1);
      if ($urandom_range(3) == 0) blur_frame(0, -1, 1'b1);
    end
  endtask

  initial begin
    radius_reg = 1; width_reg = 1024; height_reg = 1024;
    in_row = 0; in_col = 0; out_row = 0; out_col = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_extreme_sizes();
    test_aborted_frame();
    test_backpressure();
    test_random_frames();
    wait_idle();
    if (mismatches == 0)
      $display("box_blur_gray_window_core verification clean");
    else
      $display("box_blur_gray_window_core verification failed");
    $finish;
  end

endmodule
